### rtl/core/tcs_pkg.sv
// Package: shared widths, codes, result type and motif tables of the tone cue sequencer.
`default_nettype none
package tcs_pkg;

    localparam int unsigned NUM_CUES  = 7;
    localparam int unsigned ROM_NOTES = 8;
    localparam int unsigned MAX_NOTES = 4;

    localparam int unsigned CUE_W   = 3;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned FREQ_W  = 11;
    localparam int unsigned DUR_W   = 8;
    localparam int unsigned RGB_W   = 24;
    localparam int unsigned GAP_W   = 10;
    localparam int unsigned WAIT_W  = 12;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(65);

    typedef enum logic
    {
        REQ_TICK = 1'b0,
        REQ_CUE  = 1'b1
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_SOUND_ENABLE = 1'b0,
        CFG_NOTE_GAP     = 1'b1
    } cfg_idx_t;

    typedef struct packed
    {
        logic                   valid;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
    } tcs_cfg_wr_t;

    typedef struct packed
    {
        logic               speaker_stop;
        logic               flash_valid;
        logic [RGB_W-1:0]   flash_rgb;
        logic               tone_valid;
        logic [FREQ_W-1:0]  tone_freq;
        logic [DUR_W-1:0]   tone_ms;
        logic               busy_res;
    } tcs_result_t;

    localparam logic [FREQ_W-1:0] FREQ_ROM [NUM_CUES][ROM_NOTES] = '{
        '{11'd523, 11'd659, 11'd0,   11'd0,    11'd0, 11'd0, 11'd0, 11'd0},
        '{11'd659, 11'd880, 11'd0,   11'd0,    11'd0, 11'd0, 11'd0, 11'd0},
        '{11'd659, 11'd440, 11'd330, 11'd0,    11'd0, 11'd0, 11'd0, 11'd0},
        '{11'd440, 11'd440, 11'd0,   11'd0,    11'd0, 11'd0, 11'd0, 11'd0},
        '{11'd523, 11'd659, 11'd1047, 11'd0,   11'd0, 11'd0, 11'd0, 11'd0},
        '{11'd523, 11'd659, 11'd784, 11'd1047, 11'd0, 11'd0, 11'd0, 11'd0},
        '{11'd880, 11'd0,   11'd0,   11'd0,    11'd0, 11'd0, 11'd0, 11'd0}
    };

    localparam logic [DUR_W-1:0] DUR_ROM [NUM_CUES][ROM_NOTES] = '{
        '{8'd90,  8'd120, 8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd90,  8'd140, 8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd100, 8'd100, 8'd180, 8'd0,   8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd70,  8'd70,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd80,  8'd80,  8'd160, 8'd0,   8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd80,  8'd80,  8'd80,  8'd180, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd200, 8'd0,   8'd0,   8'd0,   8'd0, 8'd0, 8'd0, 8'd0}
    };

    localparam logic [CNT_W-1:0] COUNT_ROM [NUM_CUES] = '{
        4'd2, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd1
    };

    localparam logic [RGB_W-1:0] RGB_ROM [NUM_CUES] = '{
        24'h0000A0, 24'h00A000, 24'hA00000, 24'h785000,
        24'h00A000, 24'h00A000, 24'h000000
    };

    function automatic logic [CNT_W-1:0] motif_len(input logic [CUE_W-1:0] cue);
        logic [CNT_W-1:0] n;
        n = COUNT_ROM[cue];
        return (n > CNT_W'(MAX_NOTES)) ? CNT_W'(MAX_NOTES) : n;
    endfunction

endpackage
`default_nettype wire

### rtl/core/tcs_in_if.sv
// Interface: input channel carrying tick and cue request beats.
`default_nettype none
interface tcs_in_if
    import tcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CUE_W-1:0]  cue_id;

    modport source (output valid, output req_type, output cue_id, input ready);
    modport sink   (input valid, input req_type, input cue_id, output ready);
endinterface
`default_nettype wire

### rtl/core/tcs_out_if.sv
// Interface: result channel carrying speaker, flash and tone commands.
`default_nettype none
interface tcs_out_if
    import tcs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               speaker_stop;
    logic               flash_valid;
    logic [RGB_W-1:0]   flash_rgb;
    logic               tone_valid;
    logic [FREQ_W-1:0]  tone_freq;
    logic [DUR_W-1:0]   tone_ms;
    logic               busy_res;

    modport source (output valid, output speaker_stop, output flash_valid, output flash_rgb,
                    output tone_valid, output tone_freq, output tone_ms, output busy_res,
                    input ready);
    modport sink   (input valid, input speaker_stop, input flash_valid, input flash_rgb,
                    input tone_valid, input tone_freq, input tone_ms, input busy_res,
                    output ready);
endinterface
`default_nettype wire

### rtl/core/tcs_cfg_if.sv
// Interface: configuration write channel.
`default_nettype none
interface tcs_cfg_if
    import tcs_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/tone_cue_sequencer_top.sv
// Top level: tone cue sequencer with input, result and configuration channels.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  in_ch    | in  | valid / ready | req_type, cue_id
//  out_ch   | out | valid / ready | speaker_stop, flash_valid, flash_rgb,
//           |     |               | tone_valid, tone_freq, tone_ms, busy_res
//  cfg      | in  | valid / ready | index (0 sound_enable, 1 note_gap_ms), data
//
// One beat per cycle: each accepted beat yields its result beat in the next cycle.
// The single result register sets the rate; in_ch.ready drops only while it is full
// and out_ch.ready is low. cfg.ready is always high.
// Reset (rst_n low, asynchronous) empties the result register and restores defaults.
`default_nettype none
module tone_cue_sequencer_top
    import tcs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tcs_in_if.sink     in_ch,
    tcs_out_if.source  out_ch,
    tcs_cfg_if.sink    cfg
);

    tcs_cfg_wr_t  cfg_wr;
    tcs_result_t  step_result;
    tcs_result_t  out_result;
    logic         in_ready;
    logic         in_acc;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.valid = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    assign in_ch.ready = in_ready;
    assign in_acc      = in_ch.valid && in_ready;

    tcs_step u_step
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr   (cfg_wr),
        .in_acc   (in_acc),
        .req_type (in_ch.req_type),
        .cue_id   (in_ch.cue_id),
        .result   (step_result)
    );

    tcs_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ready),
        .in_result  (step_result),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_result (out_result)
    );

    assign out_ch.speaker_stop = out_result.speaker_stop;
    assign out_ch.flash_valid  = out_result.flash_valid;
    assign out_ch.flash_rgb    = out_result.flash_rgb;
    assign out_ch.tone_valid   = out_result.tone_valid;
    assign out_ch.tone_freq    = out_result.tone_freq;
    assign out_ch.tone_ms      = out_result.tone_ms;
    assign out_ch.busy_res     = out_result.busy_res;

endmodule
`default_nettype wire

### rtl/core/tcs_step.sv
// Module: configuration registers, cue state and the single-pass next-state and result logic.
`default_nettype none
module tcs_step
    import tcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tcs_cfg_wr_t       cfg_wr,
    input  wire logic              in_acc,
    input  wire logic              req_type,
    input  wire logic [CUE_W-1:0]  cue_id,
    output tcs_result_t            result
);

    logic               sound_enable_reg, sound_enable_next;
    logic [GAP_W-1:0]   note_gap_reg, note_gap_next;
    logic               pending_valid_reg, pending_valid_next;
    logic [CUE_W-1:0]   pending_cue_reg, pending_cue_next;
    logic               playing_reg, playing_next;
    logic [CUE_W-1:0]   current_cue_reg, current_cue_next;
    logic [IDX_W-1:0]   note_index_reg, note_index_next;
    logic [WAIT_W-1:0]  wait_reg, wait_next;

    always_comb
    begin
        sound_enable_next = sound_enable_reg;
        note_gap_next     = note_gap_reg;
        if (cfg_wr.valid)
        begin
            unique case (cfg_wr.index)
                CFG_SOUND_ENABLE: sound_enable_next = cfg_wr.data[0];
                CFG_NOTE_GAP:     note_gap_next     = cfg_wr.data[GAP_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        logic               start;
        logic [CUE_W-1:0]   cur;
        logic [IDX_W-1:0]   idx;
        logic [WAIT_W-1:0]  w;
        logic               pl;
        logic [DUR_W-1:0]   dur;

        pending_valid_next = pending_valid_reg;
        pending_cue_next   = pending_cue_reg;
        playing_next       = playing_reg;
        current_cue_next   = current_cue_reg;
        note_index_next    = note_index_reg;
        wait_next          = wait_reg;
        result             = '0;

        start = pending_valid_reg && (pending_cue_reg < CUE_W'(NUM_CUES));
        cur   = start ? pending_cue_reg : current_cue_reg;
        idx   = start ? '0 : note_index_reg;
        w     = start ? '0 : wait_reg;
        pl    = start ? 1'b1 : playing_reg;
        dur   = '0;

        if (in_acc)
        begin
            if (req_type == REQ_CUE)
            begin
                if (cue_id < CUE_W'(NUM_CUES))
                begin
                    pending_valid_next = 1'b1;
                    pending_cue_next   = cue_id;
                end
            end
            else
            begin
                pending_valid_next = 1'b0;
                current_cue_next   = cur;
                note_index_next    = idx;
                playing_next       = pl;
                result.speaker_stop = start;
                result.flash_valid  = start;
                result.flash_rgb    = start ? RGB_ROM[cur] : '0;
                if (pl && (cur < CUE_W'(NUM_CUES)))
                begin
                    if (w != '0)
                    begin
                        w = w - WAIT_W'(1);
                    end
                    wait_next = w;
                    if (w == '0)
                    begin
                        dur = DUR_ROM[cur][idx];
                        if (sound_enable_reg)
                        begin
                            result.tone_valid = 1'b1;
                            result.tone_freq  = FREQ_ROM[cur][idx];
                            result.tone_ms    = dur;
                        end
                        wait_next       = WAIT_W'(dur) + WAIT_W'(note_gap_reg);
                        note_index_next = idx + IDX_W'(1);
                        playing_next    = ({1'b0, idx} + CNT_W'(1)) < motif_len(cur);
                    end
                end
                else
                begin
                    wait_next    = w;
                    playing_next = 1'b0;
                end
            end
        end
        result.busy_res = playing_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg  <= 1'b1;
            note_gap_reg      <= GAP_RESET;
            pending_valid_reg <= 1'b0;
            pending_cue_reg   <= '0;
            playing_reg       <= 1'b0;
            current_cue_reg   <= '0;
            note_index_reg    <= '0;
            wait_reg          <= '0;
        end
        else
        begin
            sound_enable_reg  <= sound_enable_next;
            note_gap_reg      <= note_gap_next;
            pending_valid_reg <= pending_valid_next;
            pending_cue_reg   <= pending_cue_next;
            playing_reg       <= playing_next;
            current_cue_reg   <= current_cue_next;
            note_index_reg    <= note_index_next;
            wait_reg          <= wait_next;
        end
    end

    a_playing_cue_ok: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> (current_cue_reg < CUE_W'(NUM_CUES)))
        else $error("playing with an invalid cue");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        playing_reg |-> ({1'b0, note_index_reg} < CNT_W'(MAX_NOTES)))
        else $error("note index ran past the motif");

    a_tick_clears_mailbox: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_TICK)) |=> !pending_valid_reg)
        else $error("mailbox survived a tick");

    a_start_stops_speaker: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (req_type == REQ_TICK) && pending_valid_reg)
        |-> (result.speaker_stop && result.flash_valid))
        else $error("cue start without speaker stop");

endmodule
`default_nettype wire

### rtl/core/tcs_out_reg.sv
// Module: result register that decouples the input handshake from the result handshake.
`default_nettype none
module tcs_out_reg
    import tcs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire tcs_result_t  in_result,
    output logic              out_valid,
    input  wire logic         out_ready,
    output tcs_result_t       out_result
);

    logic         valid_reg, valid_next;
    tcs_result_t  data_reg;
    logic         load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = data_reg;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (valid_reg && !out_ready))
        else $error("input stalled with an empty result register");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("accepted beat lost");

endmodule
`default_nettype wire

### verif/testbench.sv
// Testbench: self-checking stimulus and result prediction for tone_cue_sequencer_top.
`timescale 1ns / 100ps

module testbench;
    import tcs_pkg::*;

    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned REPORT_CAP  = 40;

    logic clk;
    logic rst_n;

    tcs_in_if  in_ch();
    tcs_out_if out_ch();
    tcs_cfg_if cfg_ch();

    tone_cue_sequencer_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    logic               mb_valid;
    logic [CUE_W-1:0]   mb_cue;
    logic               seq_active;
    logic [CUE_W-1:0]   seq_cue;
    logic [IDX_W-1:0]   seq_note;
    logic [WAIT_W-1:0]  ms_left;
    logic               snd_on;
    logic [GAP_W-1:0]   gap_ms;

    tcs_result_t cue_results_due[$];

    int unsigned mismatches     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_active    = 0;
    event        hold_off_ev;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic tcs_result_t next_cue_result(req_type_t req, logic [CUE_W-1:0] cue);
        tcs_result_t       r;
        logic [IDX_W-1:0]  n;
        logic [DUR_W-1:0]  dur;
        logic [CNT_W-1:0]  len;
        r = '0;
        if (req == REQ_CUE)
        begin
            if (cue < NUM_CUES)
            begin
                mb_valid = 1'b1;
                mb_cue   = cue;
            end
        end
        else
        begin
            if (mb_valid)
            begin
                seq_cue        = mb_cue;
                seq_note       = '0;
                ms_left        = '0;
                seq_active     = 1'b1;
                r.speaker_stop = 1'b1;
                r.flash_valid  = 1'b1;
                r.flash_rgb    = RGB_ROM[seq_cue];
            end
            mb_valid = 1'b0;
            if (seq_active)
            begin
                if (ms_left != '0)
                    ms_left = ms_left - WAIT_W'(1);
                if (ms_left == '0)
                begin
                    n   = seq_note;
                    dur = DUR_ROM[seq_cue][n];
                    if (snd_on)
                    begin
                        r.tone_valid = 1'b1;
                        r.tone_freq  = FREQ_ROM[seq_cue][n];
                        r.tone_ms    = dur;
                    end
                    ms_left  = WAIT_W'(dur) + WAIT_W'(gap_ms);
                    seq_note = n + IDX_W'(1);
                    len      = COUNT_ROM[seq_cue];
                    if (len > CNT_W'(MAX_NOTES))
                        len = CNT_W'(MAX_NOTES);
                    seq_active = (CNT_W'(n) + CNT_W'(1)) < len;
                end
            end
        end
        r.busy_res = seq_active;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    endtask

    // Receiver: random ready, forced low during a hold-off
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_active)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(hold_off_ev);
            @(negedge clk);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_active = 1'b0;
        end
    end

    // Check each result beat against the oldest prediction
    initial
    begin
        tcs_result_t got;
        tcs_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                got.speaker_stop = out_ch.speaker_stop;
                got.flash_valid  = out_ch.flash_valid;
                got.flash_rgb    = out_ch.flash_rgb;
                got.tone_valid   = out_ch.tone_valid;
                got.tone_freq    = out_ch.tone_freq;
                got.tone_ms      = out_ch.tone_ms;
                got.busy_res     = out_ch.busy_res;
                if (cue_results_due.size() == 0)
                    report_mismatch("result beat with none due", 1, 0);
                else
                begin
                    want = cue_results_due.pop_front();
                    if (got.speaker_stop !== want.speaker_stop)
                        report_mismatch("speaker_stop", got.speaker_stop, want.speaker_stop);
                    if (got.flash_valid !== want.flash_valid)
                        report_mismatch("flash_valid", got.flash_valid, want.flash_valid);
                    if (got.flash_rgb !== want.flash_rgb)
                        report_mismatch("flash_rgb", got.flash_rgb, want.flash_rgb);
                    if (got.tone_valid !== want.tone_valid)
                        report_mismatch("tone_valid", got.tone_valid, want.tone_valid);
                    if (got.tone_freq !== want.tone_freq)
                        report_mismatch("tone_freq", got.tone_freq, want.tone_freq);
                    if (got.tone_ms !== want.tone_ms)
                        report_mismatch("tone_ms", got.tone_ms, want.tone_ms);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tone_cue_sequencer_top verification failed");
        $finish;
    end

    task automatic send_beat(req_type_t req, logic [CUE_W-1:0] cue);
        bit took;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= req;
        in_ch.cue_id   <= cue;
        do
        begin
            @(negedge clk);
            took = in_ch.ready;
            @(posedge clk);
        end
        while (!took);
        cue_results_due.push_back(next_cue_result(req, cue));
    endtask

    task automatic send_tick();
        send_beat(REQ_TICK, CUE_W'($urandom_range(7)));
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (cue_results_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        bit took;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
        begin
            @(negedge clk);
            took = cfg_ch.ready;
            @(posedge clk);
        end
        while (!took);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SOUND_ENABLE: snd_on = val[0];
            CFG_NOTE_GAP:     gap_ms = val;
            default:          ;
        endcase
    endtask

    task automatic set_phase(int unsigned s_pct, int unsigned r_pct, bit en,
                             logic [GAP_W-1:0] gap);
        wait_results_drained();
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        write_reg(CFG_SOUND_ENABLE, {(CFG_DATA_W-1)'($urandom_range(511)), en});
        write_reg(CFG_NOTE_GAP, gap);
    endtask

    // Mostly cue requests followed by tick runs; some loose noise beats
    task automatic run_cue_traffic(int unsigned n_items, int unsigned max_span);
        int unsigned sent;
        int unsigned reqs;
        int unsigned span;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_beat(req_type_t'($urandom_range(1)), CUE_W'($urandom_range(7)));
                sent++;
            end
            else
            begin
                reqs = $urandom_range(1, 2);
                repeat (reqs)
                begin
                    send_beat(REQ_CUE, CUE_W'($urandom_range(7)));
                    sent++;
                end
                span = $urandom_range(1, max_span);
                for (int i = 0; i < span && sent < n_items; i++)
                begin
                    send_tick();
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed_cues();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_tick();
        send_beat(REQ_TICK, CUE_W'(7));
        send_beat(REQ_CUE, CUE_W'(7));
        send_tick();
        send_beat(REQ_CUE, CUE_W'(6));
        send_beat(REQ_TICK, CUE_W'(0));
        send_tick();
        send_beat(REQ_CUE, CUE_W'(0));
        send_beat(REQ_CUE, CUE_W'(5));
        send_tick();
        send_tick();
        send_beat(REQ_CUE, CUE_W'(7));
        send_tick();
        send_beat(REQ_CUE, CUE_W'(2));
        send_tick();
        send_beat(REQ_CUE, CUE_W'(1));
        send_tick();
        send_beat(REQ_CUE, CUE_W'(3));
        send_tick();
        send_beat(REQ_CUE, CUE_W'(0));
        send_tick();
        wait_results_drained();
        write_reg(CFG_SOUND_ENABLE, CFG_DATA_W'(0));
        send_beat(REQ_CUE, CUE_W'(4));
        send_tick();
        send_tick();
        wait_results_drained();
        write_reg(CFG_SOUND_ENABLE, CFG_DATA_W'(1));
    endtask

    task automatic test_full_rate();
        set_phase(0, 0, 1'b1, GAP_W'(0));
        run_cue_traffic(380, 320);
    endtask

    task automatic test_muted_sender_gaps();
        set_phase(84, 0, 1'b0, GAP_W'($urandom_range(1, 30)));
        run_cue_traffic(320, 260);
    endtask

    task automatic test_long_gap_receiver_stalls();
        set_phase(0, 84, 1'b1, GAP_W'(1023));
        run_cue_traffic(400, 1200);
    endtask

    task automatic test_both_idle();
        set_phase(8, 8, 1'b1, GAP_RESET);
        run_cue_traffic(420, 300);
    endtask

    task automatic test_input_backpressure();
        set_phase(0, 0, 1'($urandom_range(1)), GAP_W'($urandom_range(0, 20)));
        -> hold_off_ev;
        run_cue_traffic(30, 12);
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.req_type <= REQ_TICK;
        in_ch.cue_id   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= CFG_SOUND_ENABLE;
        cfg_ch.data    <= '0;
        mb_valid   = 1'b0;
        mb_cue     = '0;
        seq_active = 1'b0;
        seq_cue    = '0;
        seq_note   = '0;
        ms_left    = '0;
        snd_on     = 1'b1;
        gap_ms     = GAP_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cues();
        test_full_rate();
        test_muted_sender_gaps();
        test_long_gap_receiver_stalls();
        test_both_idle();
        test_input_backpressure();

        in_ch.valid <= 1'b0;
        for (int i = 0; i < 2000 && cue_results_due.size() != 0; i++)
            @(posedge clk);
        if (cue_results_due.size() != 0)
            report_mismatch("result beats never delivered", 0, cue_results_due.size());
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tone_cue_sequencer_top verification clean");
        else
            $display("tone_cue_sequencer_top verification failed");
        $finish;
    end

endmodule

### files.f
rtl/core/tcs_pkg.sv
rtl/core/tcs_in_if.sv
rtl/core/tcs_out_if.sv
rtl/core/tcs_cfg_if.sv
rtl/core/tcs_step.sv
rtl/core/tcs_out_reg.sv
rtl/core/tone_cue_sequencer_top.sv
verif/testbench.sv
